@@ rtl/core/gnl_pkg.sv @@
// shared types, constants and helper functions of the grid neighbor cell lister
// used by every module of the block, no dependencies
package gnl_pkg;

  localparam int GRID_DIM_MAX    = 256;
  localparam int SCAN_RADIUS_MAX = 3;

  localparam int CoordW = $clog2(GRID_DIM_MAX);
  localparam int DimW   = 9;
  localparam int RadW   = 2;
  localparam int CellW  = 16;
  localparam int AreaW  = 2 * DimW;
  localparam int CfgIdxW = 2;
  localparam int QDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_SCAN_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              bad;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } job_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] res;
    res = v;
    if (v == '0) begin
      res = DimW'(1);
    end else if (v > DimW'(GRID_DIM_MAX)) begin
      res = DimW'(GRID_DIM_MAX);
    end
    return res;
  endfunction

  function automatic logic [RadW-1:0] clamp_radius(input logic [RadW-1:0] v);
    logic [RadW-1:0] res;
    res = v;
    if (v > RadW'(SCAN_RADIUS_MAX)) begin
      res = RadW'(SCAN_RADIUS_MAX);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/gnl_front.sv @@
// front end: takes a centre cell, checks it against the grid area and
// splits it into column and row with a bit-serial divider; uses gnl_pkg
module gnl_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [gnl_pkg::CellW-1:0] centre_cell_i,
  input  logic [gnl_pkg::DimW-1:0]  width_i,
  input  logic [gnl_pkg::DimW-1:0]  height_i,
  output logic                     push_o,
  output gnl_pkg::job_t            job_o,
  input  logic                     full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CHECK,
    F_DIV,
    F_PUSH
  } front_state_e;

  localparam int CntW = (gnl_pkg::CoordW > 1) ? $clog2(gnl_pkg::CoordW) : 1;

  front_state_e                  state_q;
  logic [gnl_pkg::CellW-1:0]     cell_q;
  logic [gnl_pkg::DimW-1:0]      rem_q;
  logic [gnl_pkg::CoordW-1:0]    quot_q;
  logic [CntW-1:0]               cnt_q;
  logic                          bad_q;

  logic [gnl_pkg::AreaW-1:0]     area;
  logic                          outside;
  logic [gnl_pkg::DimW:0]        trial;
  logic [gnl_pkg::DimW:0]        diff;
  logic                          ge;

  always_comb begin
    area    = gnl_pkg::AreaW'(width_i) * gnl_pkg::AreaW'(height_i);
    outside = gnl_pkg::AreaW'(cell_q) >= area;
    trial   = {rem_q, cell_q[gnl_pkg::CellW-1]};
    diff    = trial - {1'b0, width_i};
    ge      = trial >= {1'b0, width_i};
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign job_o      = '{bad: bad_q, col: rem_q[gnl_pkg::CoordW-1:0], row: quot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cell_q  <= '0;
      rem_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            cell_q  <= centre_cell_i;
            state_q <= F_CHECK;
          end
        end
        F_CHECK: begin
          bad_q <= outside;
          cnt_q <= '0;
          if (outside) begin
            rem_q   <= '0;
            quot_q  <= '0;
            state_q <= F_PUSH;
          end else begin
            rem_q   <= gnl_pkg::DimW'(cell_q >> gnl_pkg::CoordW);
            cell_q  <= cell_q << gnl_pkg::CoordW;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          cell_q <= cell_q << 1;
          quot_q <= gnl_pkg::CoordW'({quot_q, ge});
          if (ge) begin
            rem_q <= diff[gnl_pkg::DimW-1:0];
          end else begin
            rem_q <= trial[gnl_pkg::DimW-1:0];
          end
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(gnl_pkg::CoordW - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/gnl_fifo.sv @@
// short job queue between front end and back end
// uses gnl_pkg for the job type and depth
module gnl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gnl_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gnl_pkg::job_t job_o
);

  localparam int PtrW = (gnl_pkg::QDepth > 1) ? $clog2(gnl_pkg::QDepth) : 1;
  localparam int CntW = $clog2(gnl_pkg::QDepth + 1);

  gnl_pkg::job_t   mem_q [gnl_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(gnl_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(gnl_pkg::QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(gnl_pkg::QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/core/gnl_back.sv @@
// back end: takes a job from the queue, clips the window at the grid borders
// and walks it row by row into the output register; uses gnl_pkg
module gnl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gnl_pkg::DimW-1:0]  width_i,
  input  logic [gnl_pkg::DimW-1:0]  height_i,
  input  logic [gnl_pkg::RadW-1:0]  radius_i,
  input  logic                      q_valid_i,
  input  gnl_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [gnl_pkg::CellW-1:0] seen_cell_o,
  output logic                      last_cell_o,
  output logic                      bad_index_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_BOUND,
    B_BASE,
    B_EMIT
  } back_state_e;

  localparam int DimW   = gnl_pkg::DimW;
  localparam int CoordW = gnl_pkg::CoordW;
  localparam int CellW  = gnl_pkg::CellW;

  back_state_e       state_q;
  gnl_pkg::job_t     job_q;
  logic [CoordW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [CellW-1:0]  base_q;
  logic              out_valid_q;
  logic [CellW-1:0]  seen_q;
  logic              last_q;
  logic              bad_q;

  logic [DimW-1:0]   col_ext, row_ext, rad_ext, wmax, hmax;
  logic [DimW-1:0]   col_sum, row_sum;
  logic [CoordW-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [DimW+CoordW-1:0] base_prod;
  logic              fire;
  logic              at_end;
  logic              row_end;

  always_comb begin
    col_ext = DimW'(job_q.col);
    row_ext = DimW'(job_q.row);
    rad_ext = DimW'(radius_i);
    wmax    = width_i - DimW'(1);
    hmax    = height_i - DimW'(1);
    col_sum = col_ext + rad_ext;
    row_sum = row_ext + rad_ext;
    x0_d = (col_ext >= rad_ext) ? CoordW'(col_ext - rad_ext) : '0;
    y0_d = (row_ext >= rad_ext) ? CoordW'(row_ext - rad_ext) : '0;
    x1_d = (col_sum > wmax) ? CoordW'(wmax) : CoordW'(col_sum);
    y1_d = (row_sum > hmax) ? CoordW'(hmax) : CoordW'(row_sum);
    if (job_q.bad) begin
      x0_d = '0;
      x1_d = '0;
      y0_d = '0;
      y1_d = '0;
    end
    base_prod = (DimW + CoordW)'(y0_q) * (DimW + CoordW)'(width_i);
    fire    = (state_q == B_EMIT) && (!out_valid_q || !out_stall_i);
    row_end = (x_q == x1_q);
    at_end  = row_end && (y_q == y1_q);
  end

  assign pop_o       = (state_q == B_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign seen_cell_o = seen_q;
  assign last_cell_o = last_q;
  assign bad_index_o = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      job_q       <= '0;
      x0_q        <= '0;
      x1_q        <= '0;
      y0_q        <= '0;
      y1_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      last_q      <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        seen_q      <= base_q + CellW'(x_q);
        last_q      <= at_end;
        bad_q       <= job_q.bad;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            job_q   <= job_i;
            state_q <= B_BOUND;
          end
        end
        B_BOUND: begin
          x0_q    <= x0_d;
          x1_q    <= x1_d;
          y0_q    <= y0_d;
          y1_q    <= y1_d;
          state_q <= B_BASE;
        end
        B_BASE: begin
          base_q  <= CellW'(base_prod);
          x_q     <= x0_q;
          y_q     <= y0_q;
          state_q <= B_EMIT;
        end
        B_EMIT: begin
          if (fire) begin
            if (at_end) begin
              state_q <= B_IDLE;
            end else if (row_end) begin
              x_q    <= x0_q;
              y_q    <= y_q + CoordW'(1);
              base_q <= base_q + CellW'(width_i);
            end else begin
              x_q <= x_q + CoordW'(1);
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/grid_neighbor_cell_lister.sv @@
// Top level of the grid neighbor cell lister: config registers, front end,
// job queue and back end. Depends on gnl_pkg, gnl_front, gnl_fifo, gnl_back.
//
// Each center cell index is split into column and row by a one-bit-a-cycle
// divider in the front end (steps per item: capture, area check, 8 divide
// steps unless the index is outside the grid, queue push). The back end
// then runs its setup (queue pop, border clipping, row base multiply) and
// emits one window cell per cycle while the output is not stalled, row by
// row, left to right, last_cell set on the final one; a center index at or
// past width * height yields one item with bad_index set and seen_cell 0.
// The two ends overlap through a two-entry job queue, so the sustained rate
// is set by the back end's setup and walk over the clipped window (1 to 49
// cells), or by the front end's divider when the window is small.
// Config writes are always taken (cfg_ready_o high) and must only happen
// while the block is idle.
module grid_neighbor_cell_lister (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gnl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gnl_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gnl_pkg::CellW-1:0]    centre_cell_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gnl_pkg::CellW-1:0]    seen_cell_o,
  output logic                         last_cell_o,
  output logic                         bad_index_o
);

  logic [gnl_pkg::DimW-1:0] grid_width_q;
  logic [gnl_pkg::DimW-1:0] grid_height_q;
  logic [gnl_pkg::RadW-1:0] scan_radius_q;
  logic [gnl_pkg::DimW-1:0] width_eff;
  logic [gnl_pkg::DimW-1:0] height_eff;
  logic [gnl_pkg::RadW-1:0] radius_eff;

  logic          front_stall;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  gnl_pkg::job_t push_job;
  gnl_pkg::job_t pop_job;

  assign cfg_ready_o = 1'b1;
  assign width_eff   = gnl_pkg::clamp_dim(grid_width_q);
  assign height_eff  = gnl_pkg::clamp_dim(grid_height_q);
  assign radius_eff  = gnl_pkg::clamp_radius(scan_radius_q);
  assign in_stall_o  = front_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= gnl_pkg::DimW'(64);
      grid_height_q <= gnl_pkg::DimW'(64);
      scan_radius_q <= gnl_pkg::RadW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gnl_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        gnl_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        gnl_pkg::CFG_SCAN_RADIUS: scan_radius_q <= cfg_data_i[gnl_pkg::RadW-1:0];
        default: ;
      endcase
    end
  end

  gnl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (front_stall),
    .centre_cell_i (centre_cell_i),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .push_o        (q_push),
    .job_o         (push_job),
    .full_i        (q_full)
  );

  gnl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  gnl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .radius_i    (radius_eff),
    .q_valid_i   (q_valid),
    .job_i       (pop_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .seen_cell_o (seen_cell_o),
    .last_cell_o (last_cell_o),
    .bad_index_o (bad_index_o)
  );

  // an out-of-grid center gives exactly one item, cell zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> last_cell_o && (seen_cell_o == '0))
    else $error("bad index item not a single zero cell");

  // queue never written while full or read while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full) && !(q_pop && !q_valid))
    else $error("job queue overflow or underflow");

  // a good window cell lies inside the grid area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_index_o |->
      (gnl_pkg::AreaW'(seen_cell_o) <
       gnl_pkg::AreaW'(width_eff) * gnl_pkg::AreaW'(height_eff)))
    else $error("window cell outside grid");

endmodule
